[rtl/split_band_scroll_address_macros.svh]
// Assertion macros shared by the split-band scroll address block.
`ifndef SPLIT_BAND_SCROLL_ADDRESS_MACROS_SVH
`define SPLIT_BAND_SCROLL_ADDRESS_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk outside reset.
`define SBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SBA_ASSERT(lbl, prop, msg)

`define SBA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[rtl/sba_pkg.sv]
package sba_pkg;

  localparam int MAX_WIDTH_DEFAULT  = 4096;
  localparam int MAX_HEIGHT_DEFAULT = 4096;

  localparam int CFG_W       = 13;
  localparam int CFG_INDEX_W = 3;
  localparam int COORD_W     = 12;
  localparam int DIV_W       = CFG_W + 1;

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  localparam logic [CFG_W-1:0] DIVIDER_RESET      = 13'd4;
  localparam logic [CFG_W-1:0] TOP_Y_SPEED_RESET  = 13'd0;
  localparam logic [CFG_W-1:0] BOT_Y_SPEED_RESET  = 13'd0;
  localparam logic [CFG_W-1:0] TOP_X_SPEED_RESET  = 13'd1;
  localparam logic [CFG_W-1:0] BOT_X_SPEED_RESET  = 13'd2;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DIVIDER,
    REG_TOP_Y_SPEED,
    REG_BOT_Y_SPEED,
    REG_TOP_X_SPEED,
    REG_BOT_X_SPEED,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_reg_t;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic               in_top_band;
    logic               outside_frame;
  } rsp_t;

  // Division steps run by the shared divider, in sequence order.
  typedef enum logic [3:0] {
    STEP_TOP_ROWS,
    STEP_TRO,
    STEP_TYS,
    STEP_TCO,
    STEP_TXS,
    STEP_BRO,
    STEP_BYS,
    STEP_BCO,
    STEP_BXS,
    STEP_RTR,
    STEP_RTC,
    STEP_RBR,
    STEP_RBC
  } step_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_START,
    S_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic  capture;
    logic  div_start;
    logic  write;
    logic  mark_dirty;
    logic  clear_dirty;
    logic  out_load;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic div_busy;
    logic op_pixel;
    logic dirty;
    logic out_free;
  } status_t;

endpackage

[rtl/sba_div.sv]
module sba_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sba_pkg::DIV_W-1:0] dividend,
  input  logic [sba_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [sba_pkg::DIV_W-1:0] quotient,
  output logic [sba_pkg::DIV_W-1:0] remainder
);
  import sba_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             zero_div;
  logic [DIV_W:0]   shifted;
  logic [DIV_W:0]   diff;

  assign shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quo      <= dividend;
      dsr      <= divisor;
      zero_div <= (divisor == '0);
      cnt      <= CNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (!diff[DIV_W]) begin
        rem <= diff;
        quo <= {quo[DIV_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DIV_W-2:0], 1'b0};
      end
    end
  end

  // A zero divisor yields zero, as an empty span does.
  assign quotient  = zero_div ? '0 : quo;
  assign remainder = zero_div ? '0 : rem[DIV_W-1:0];

endmodule

[rtl/sba_datapath.sv]
module sba_datapath #(
  parameter int MAX_WIDTH  = sba_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = sba_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sba_pkg::CFG_W-1:0]       cfg_data,
  input  sba_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output sba_pkg::rsp_t                   rsp,
  input  sba_pkg::cmd_t                   cmd,
  output sba_pkg::status_t                status
);
  import sba_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int ROWS_W = $clog2(MAX_HEIGHT + 1);

  logic [CFG_W-1:0] divider_setting;
  logic [CFG_W-1:0] top_y_speed;
  logic [CFG_W-1:0] bot_y_speed;
  logic [CFG_W-1:0] top_x_speed;
  logic [CFG_W-1:0] bot_x_speed;
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  logic [ROWS_W-1:0] top_rows;
  logic [ROW_W-1:0]  top_row_offset;
  logic [COL_W-1:0]  top_col_offset;
  logic [ROW_W-1:0]  bottom_row_offset;
  logic [COL_W-1:0]  bottom_col_offset;

  // Offsets reduced modulo the spans of the current geometry.
  logic [ROW_W-1:0] red_top_row;
  logic [COL_W-1:0] red_top_col;
  logic [ROW_W-1:0] red_bot_row;
  logic [COL_W-1:0] red_bot_col;
  logic             dirty;

  logic [DIV_W-1:0] tmp;
  req_t             item;

  logic [DIV_W-1:0] w;
  logic [DIV_W-1:0] h;
  logic [DIV_W-1:0] tr;
  logic [DIV_W-1:0] bspan;
  logic [DIV_W-1:0] div_clamped;
  logic [DIV_W-1:0] div_a;
  logic [DIV_W-1:0] div_d;
  logic             div_busy;
  logic             div_done;
  logic [DIV_W-1:0] div_q;
  logic [DIV_W-1:0] div_r;
  rsp_t             rsp_d;

  function automatic logic [DIV_W-1:0] add_mod(input logic [DIV_W-1:0] a,
                                               input logic [DIV_W-1:0] b,
                                               input logic [DIV_W-1:0] span);
    logic [DIV_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, span}) begin
      sum = sum - {1'b0, span};
    end
    return sum[DIV_W-1:0];
  endfunction

  assign w  = (DIV_W'(frame_width) > DIV_W'(MAX_WIDTH)) ? DIV_W'(MAX_WIDTH)
                                                        : DIV_W'(frame_width);
  assign h  = (DIV_W'(frame_height) > DIV_W'(MAX_HEIGHT)) ? DIV_W'(MAX_HEIGHT)
                                                          : DIV_W'(frame_height);
  assign tr = DIV_W'(top_rows);
  assign bspan = (h > tr) ? h - tr : '0;

  always_comb begin
    div_clamped = (divider_setting == '0) ? DIV_W'(1) : DIV_W'(divider_setting);
    if (h != '0 && div_clamped > h) begin
      div_clamped = h;
    end
  end

  always_comb begin
    div_a = '0;
    div_d = w;
    case (cmd.step)
      STEP_TOP_ROWS: begin
        div_a = h;
        div_d = div_clamped;
      end
      STEP_TRO, STEP_RTR: begin
        div_a = DIV_W'(top_row_offset);
        div_d = tr;
      end
      STEP_TYS: begin
        div_a = DIV_W'(top_y_speed);
        div_d = tr;
      end
      STEP_TCO, STEP_RTC: begin
        div_a = DIV_W'(top_col_offset);
      end
      STEP_TXS: begin
        div_a = DIV_W'(top_x_speed);
      end
      STEP_BRO, STEP_RBR: begin
        div_a = DIV_W'(bottom_row_offset);
        div_d = bspan;
      end
      STEP_BYS: begin
        div_a = DIV_W'(bot_y_speed);
        div_d = bspan;
      end
      STEP_BCO, STEP_RBC: begin
        div_a = DIV_W'(bottom_col_offset);
      end
      STEP_BXS: begin
        div_a = DIV_W'(bot_x_speed);
      end
      default: begin
        div_a = '0;
      end
    endcase
  end

  sba_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_d),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_setting <= DIVIDER_RESET;
      top_y_speed     <= TOP_Y_SPEED_RESET;
      bot_y_speed     <= BOT_Y_SPEED_RESET;
      top_x_speed     <= TOP_X_SPEED_RESET;
      bot_x_speed     <= BOT_X_SPEED_RESET;
      frame_width     <= FRAME_WIDTH_RESET;
      frame_height    <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIVIDER:      divider_setting <= cfg_data;
        REG_TOP_Y_SPEED:  top_y_speed     <= cfg_data;
        REG_BOT_Y_SPEED:  bot_y_speed     <= cfg_data;
        REG_TOP_X_SPEED:  top_x_speed     <= cfg_data;
        REG_BOT_X_SPEED:  bot_x_speed     <= cfg_data;
        REG_FRAME_WIDTH:  frame_width     <= cfg_data;
        REG_FRAME_HEIGHT: frame_height    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dirty <= 1'b1;
    end else if (cfg_we || cmd.mark_dirty) begin
      dirty <= 1'b1;
    end else if (cmd.clear_dirty) begin
      dirty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_rows          <= '0;
      top_row_offset    <= '0;
      top_col_offset    <= '0;
      bottom_row_offset <= '0;
      bottom_col_offset <= '0;
      red_top_row       <= '0;
      red_top_col       <= '0;
      red_bot_row       <= '0;
      red_bot_col       <= '0;
    end else if (cmd.write) begin
      case (cmd.step)
        STEP_TOP_ROWS: top_rows <= ROWS_W'(div_q);
        STEP_TYS: top_row_offset <= ROW_W'(add_mod(tmp, div_r, tr));
        STEP_TXS: top_col_offset <= COL_W'(add_mod(tmp, div_r, w));
        STEP_BYS: begin
          if (bspan != '0) begin
            bottom_row_offset <= ROW_W'(add_mod(tmp, div_r, bspan));
          end
        end
        STEP_BXS: begin
          if (bspan != '0) begin
            bottom_col_offset <= COL_W'(add_mod(tmp, div_r, w));
          end
        end
        STEP_RTR: red_top_row <= ROW_W'(div_r);
        STEP_RTC: red_top_col <= COL_W'(div_r);
        STEP_RBR: red_bot_row <= ROW_W'(div_r);
        STEP_RBC: red_bot_col <= COL_W'(div_r);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      tmp <= div_r;
    end
    if (cmd.capture) begin
      item <= req;
    end
  end

  always_comb begin
    logic [DIV_W-1:0] x;
    logic [DIV_W-1:0] y;
    logic [DIV_W-1:0] sx;
    logic [DIV_W-1:0] sy;
    logic [DIV_W-1:0] col_off;
    logic             top;
    x       = DIV_W'(item.pixel_x);
    y       = DIV_W'(item.pixel_y);
    top     = (y < tr);
    col_off = top ? DIV_W'(red_top_col) : DIV_W'(red_bot_col);
    sx      = add_mod(x, col_off, w);
    if (top) begin
      sy = add_mod(y, DIV_W'(red_top_row), tr);
    end else begin
      sy = tr + add_mod(y - tr, DIV_W'(red_bot_row), bspan);
    end
    rsp_d = '0;
    if (x >= w || y >= h) begin
      rsp_d.src_x         = item.pixel_x;
      rsp_d.src_y         = item.pixel_y;
      rsp_d.outside_frame = 1'b1;
    end else if (top_rows == '0) begin
      rsp_d.src_x = item.pixel_x;
      rsp_d.src_y = item.pixel_y;
    end else begin
      rsp_d.src_x       = sx[COORD_W-1:0];
      rsp_d.src_y       = sy[COORD_W-1:0];
      rsp_d.in_top_band = top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp <= rsp_d;
    end
  end

  assign status.div_done = div_done;
  assign status.div_busy = div_busy;
  assign status.op_pixel = (item.op == OP_PIXEL);
  assign status.dirty    = dirty;
  assign status.out_free = !rsp_valid || rsp_ready;

endmodule

[rtl/sba_ctrl.sv]
`include "split_band_scroll_address_macros.svh"

module sba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  sba_pkg::status_t status,
  output sba_pkg::cmd_t    cmd
);
  import sba_pkg::*;

  state_t state;
  state_t state_next;
  step_t  step;
  step_t  step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= STEP_TOP_ROWS;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!status.op_pixel) begin
          step_next  = STEP_TOP_ROWS;
          state_next = S_START;
        end else if (status.dirty) begin
          step_next  = STEP_RTR;
          state_next = S_START;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_START: begin
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (status.div_done) begin
          if (step == STEP_BXS) begin
            state_next = S_IDLE;
          end else if (step == STEP_RBC) begin
            state_next = S_EMIT;
          end else begin
            step_next  = step_t'(step + 4'd1);
            state_next = S_START;
          end
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready       = (state == S_IDLE);
    cmd.capture     = req_ready && req_valid;
    cmd.div_start   = (state == S_START);
    cmd.write       = (state == S_WAIT) && status.div_done;
    cmd.mark_dirty  = cmd.write && (step == STEP_BXS);
    cmd.clear_dirty = cmd.write && (step == STEP_RBC);
    cmd.out_load    = (state == S_EMIT) && status.out_free;
    cmd.step        = step;
  end

  `SBA_ASSERT(a_done_in_wait, status.div_done |-> state == S_WAIT, "divider finished outside wait")
  `SBA_ASSERT(a_start_idle_div, state == S_START |-> !status.div_busy, "divider started while busy")
  `SBA_ASSERT(a_emit_pixel, state == S_EMIT |-> status.op_pixel, "result for an advance item")
  `SBA_ASSERT_ALWAYS(a_reset_idle, $fell(rst) |-> state == S_IDLE, "not idle after reset")

endmodule

[rtl/split_band_scroll_address.sv]
// Channel   Signals                         Moves
// req       req_valid, req_ready, req       one item: frame advance or pixel request
// rsp       rsp_valid, rsp_ready, rsp       one item: source coordinates and flags
// cfg       cfg_we, cfg_index, cfg_data     register write, no handshake
//
// A pixel item passes through decode and emit when the geometry is unchanged since
// the last reduction; after a register write or an advance it first runs four divisions.
// A frame advance runs nine divisions in turn on the shared restoring divider.
// Reset is synchronous and needs no
// clearing pass. The output register lets a new item enter while a result waits.
module split_band_scroll_address #(
  parameter int MAX_WIDTH  = sba_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = sba_pkg::MAX_HEIGHT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  sba_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output sba_pkg::rsp_t                   rsp,
  input  logic                            cfg_we,
  input  logic [sba_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sba_pkg::CFG_W-1:0]       cfg_data
);
  import sba_pkg::*;

  cmd_t    cmd;
  status_t status;

  sba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  sba_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
